// ===== design/pc3_pkg.sv =====
// ----------------------------------------------------------------------------
// pc3_pkg
// Shared types of the three-point curvature unit: the command and status
// words between the sequencer and the bit-serial arithmetic engine.
// ----------------------------------------------------------------------------
package pc3_pkg;

  // Operation run by the arithmetic engine
  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_SQRT = 2'd1,
    OP_DIV  = 2'd2,
    OP_ACOS = 2'd3
  } eng_op_e;

  typedef struct packed {
    logic       go;
    eng_op_e    op;
    logic [4:0] fbits;
  } eng_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } eng_stat_t;

endpackage

// ===== design/pc3_if.sv =====
// ----------------------------------------------------------------------------
// pc3 channel interfaces
// Valid/ready channels for path points and curvature results.
// ----------------------------------------------------------------------------
interface pc3_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic               end_of_path;

  modport source (output valid, pos_x, pos_y, end_of_path, input ready);
  modport sink   (input valid, pos_x, pos_y, end_of_path, output ready);
endinterface

interface pc3_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] curvature;
  logic signed [31:0] curvature_rate;
  logic signed [31:0] curvature_accel;
  logic               last_of_path;

  modport source (output valid, curvature, curvature_rate, curvature_accel,
                  last_of_path, input ready);
  modport sink   (input valid, curvature, curvature_rate, curvature_accel,
                  last_of_path, output ready);
endinterface

// ===== design/path_curvature_three_point_unit.sv =====
// ----------------------------------------------------------------------------
// path_curvature_three_point_unit
// Three-point curvature of a 2-D path with its first and second derivative
// over segment length.
// ----------------------------------------------------------------------------
// Usage:
//   point_i carries one path point a word (Q15.16 x, y and an end flag);
//   result_o carries curvature, its rate and accel in Q6.25 and a last flag.
//   Each interior point is reported when the following point arrives; the
//   first and last points of a path report zeros, and the last point's word
//   carries last_of_path.
// Sequence:
//   An interior point runs a chain of bit-serial operations in one shared
//   engine: 12 multiplies, 5 square roots, a CORDIC arc cosine and the
//   divides; a zero chord or segment cuts it short. A new point is taken
//   only once the word of the last one has been passed to the output
//   register. An end of path adds one more word.
// Reset:
//   Clears the point history, the derivative history and the output valid flag.
// Stall:
//   A finished word waits in the output register; the next point is taken
//   meanwhile, and the unit holds before its next word until the slot frees.
// ----------------------------------------------------------------------------
module path_curvature_three_point_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  pc3_point_if.sink           point_i,
  pc3_result_if.source        result_o
);
  import pc3_pkg::*;

  localparam logic [4:0]  CosFracBits = 5'd30;
  localparam logic [4:0]  KFracBits   = 5'(FRAC_BITS - 5);
  localparam logic [4:0]  DsFracBits  = 5'(FRAC_BITS);
  localparam logic [32:0] Q30One      = 33'h040000000;
  localparam logic [32:0] CurvMax     = 33'h07FFFFFFF;
  localparam logic [32:0] CurvNegMax  = 33'h080000000;
  localparam logic [63:0] OneQ60      = 64'h1000000000000000;

  typedef enum logic [24:0] {
    S_IDLE   = 25'h0000001,
    S_CH_X   = 25'h0000002,
    S_CH_Y   = 25'h0000004,
    S_CH_R   = 25'h0000008,
    S_LA_X   = 25'h0000010,
    S_LA_Y   = 25'h0000020,
    S_LA_R   = 25'h0000040,
    S_LB_X   = 25'h0000080,
    S_LB_Y   = 25'h0000100,
    S_LB_R   = 25'h0000200,
    S_DOT_A  = 25'h0000400,
    S_DOT_B  = 25'h0000800,
    S_DEN    = 25'h0001000,
    S_COS    = 25'h0002000,
    S_CM     = 25'h0004000,
    S_SIN    = 25'h0008000,
    S_ACOS   = 25'h0010000,
    S_KDIV   = 25'h0020000,
    S_DS_X   = 25'h0040000,
    S_DS_Y   = 25'h0080000,
    S_DS_R   = 25'h0100000,
    S_RATE   = 25'h0200000,
    S_ACC    = 25'h0400000,
    S_PUSH_K = 25'h0800000,
    S_PUSH_E = 25'h1000000
  } state_e;

  function automatic logic [32:0] mag33(input logic [32:0] v);
    return v[32] ? (~v + 33'd1) : v;
  endfunction

  // right shift that brings both magnitudes below 2^31
  function automatic logic [1:0] seg_shift(input logic [32:0] a, input logic [32:0] b);
    logic [1:0] s;
    if (a[32] | b[32])      s = 2'd2;
    else if (a[31] | b[31]) s = 2'd1;
    else                    s = 2'd0;
    return s;
  endfunction

  // right shift that brings the largest magnitude below 2^30
  function automatic logic [1:0] scale_shift(input logic [32:0] m);
    logic [1:0] s;
    if (m[32])      s = 2'd3;
    else if (m[31]) s = 2'd2;
    else if (m[30]) s = 2'd1;
    else            s = 2'd0;
    return s;
  endfunction

  state_e st_q;
  logic   run_q;
  logic [1:0] ps_q;
  logic       acc_on_q;
  logic [31:0] ox_q, oy_q, nx_q, ny_q, px_q, py_q, pk_q, pr_q;
  logic        end_q;
  logic [32:0] cdx_q, cdy_q, ux_q, uy_q, vx_q, vy_q;
  logic [63:0] sum_q, dot_q;
  logic [33:0] chord_q, ds_q;
  logic [30:0] la_q, lb_q;
  logic [31:0] cq_q, sn_q, acos_q, k_q, rate_q, accl_q;
  logic        ov_q, ol_q;
  logic [31:0] ok_q, or_q, oa_q;

  eng_cmd_t    cmd;
  eng_stat_t   stat;
  logic [63:0] opa, opb, res;
  logic [32:0] cap;
  logic        comp, eng_done, slot_free, accept, push;

  logic [32:0] cmx, cmy, mux, muy, mvx, mvy, dk, dr, dk_m, dr_m;
  logic [1:0]  s_ch, s_sc, s_ds;
  logic [31:0] chx, chy, dsx, dsy, cm;
  logic [29:0] sux, suy, svx, svy;
  logic [33:0] chord_d, ds_d;
  logic [63:0] dot_m, p_sgn_a, p_sgn_b;
  state_e      after_k;

  // Derived operands
  always_comb begin
    cmx   = mag33(cdx_q);
    cmy   = mag33(cdy_q);
    mux   = mag33(ux_q);
    muy   = mag33(uy_q);
    mvx   = mag33(vx_q);
    mvy   = mag33(vy_q);
    s_ch  = seg_shift(cmx, cmy);
    s_ds  = seg_shift(mux, muy);
    s_sc  = scale_shift(mux | muy | mvx | mvy);
    chx   = 32'(cmx >> s_ch);
    chy   = 32'(cmy >> s_ch);
    dsx   = 32'(mux >> s_ds);
    dsy   = 32'(muy >> s_ds);
    sux   = 30'(mux >> s_sc);
    suy   = 30'(muy >> s_sc);
    svx   = 30'(mvx >> s_sc);
    svy   = 30'(mvy >> s_sc);
    chord_d = {2'b00, res[31:0]} << s_ch;
    ds_d    = {2'b00, res[31:0]} << s_ds;
    p_sgn_a = (ux_q[32] ^ vx_q[32]) ? (~res + 64'd1) : res;
    p_sgn_b = (uy_q[32] ^ vy_q[32]) ? (~res + 64'd1) : res;
    dot_m = dot_q[63] ? (~dot_q + 64'd1) : dot_q;
    cm    = cq_q[31] ? (~cq_q + 32'd1) : cq_q;
    dk    = {k_q[31], k_q} - {pk_q[31], pk_q};
    dr    = {rate_q[31], rate_q} - {pr_q[31], pr_q};
    dk_m  = mag33(dk);
    dr_m  = mag33(dr);
    after_k = (ps_q == 2'd3) ? S_DS_X : S_PUSH_K;
  end

  // Engine command for the current step
  always_comb begin
    cmd   = '0;
    opa   = '0;
    opb   = '0;
    cap   = '0;
    comp  = 1'b1;
    case (st_q)
      S_CH_X:  begin opa = {32'd0, chx}; opb = {32'd0, chx}; end
      S_CH_Y:  begin opa = {32'd0, chy}; opb = {32'd0, chy}; end
      S_CH_R:  begin cmd.op = OP_SQRT; opa = sum_q; end
      S_LA_X:  begin opa = {34'd0, sux}; opb = {34'd0, sux}; end
      S_LA_Y:  begin opa = {34'd0, suy}; opb = {34'd0, suy}; end
      S_LA_R:  begin cmd.op = OP_SQRT; opa = sum_q; end
      S_LB_X:  begin opa = {34'd0, svx}; opb = {34'd0, svx}; end
      S_LB_Y:  begin opa = {34'd0, svy}; opb = {34'd0, svy}; end
      S_LB_R:  begin cmd.op = OP_SQRT; opa = sum_q; end
      S_DOT_A: begin opa = {34'd0, sux}; opb = {34'd0, svx}; end
      S_DOT_B: begin opa = {34'd0, suy}; opb = {34'd0, svy}; end
      S_DEN:   begin opa = {33'd0, la_q}; opb = {33'd0, lb_q}; end
      S_COS: begin
        cmd.op = OP_DIV; cmd.fbits = CosFracBits;
        opa = dot_m; opb = sum_q; cap = Q30One;
      end
      S_CM:    begin opa = {32'd0, cm}; opb = {32'd0, cm}; end
      S_SIN:   begin cmd.op = OP_SQRT; opa = OneQ60 - sum_q; end
      S_ACOS:  begin cmd.op = OP_ACOS; opa = {{32{cq_q[31]}}, cq_q}; opb = {32'd0, sn_q}; end
      S_KDIV: begin
        cmd.op = OP_DIV; cmd.fbits = KFracBits;
        opa = {32'd0, acos_q}; opb = {30'd0, chord_q}; cap = CurvMax;
      end
      S_DS_X:  begin opa = {32'd0, dsx}; opb = {32'd0, dsx}; end
      S_DS_Y:  begin opa = {32'd0, dsy}; opb = {32'd0, dsy}; end
      S_DS_R:  begin cmd.op = OP_SQRT; opa = sum_q; end
      S_RATE: begin
        cmd.op = OP_DIV; cmd.fbits = DsFracBits;
        opa = {31'd0, dk_m}; opb = {30'd0, ds_q}; cap = dk[32] ? CurvNegMax : CurvMax;
      end
      S_ACC: begin
        cmd.op = OP_DIV; cmd.fbits = DsFracBits;
        opa = {31'd0, dr_m}; opb = {30'd0, ds_q}; cap = dr[32] ? CurvNegMax : CurvMax;
      end
      default: comp = 1'b0;
    endcase
    cmd.go = comp && !run_q;
  end

  pc3_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .opa_i  (opa),
    .opb_i  (opb),
    .cap_i  (cap),
    .stat_o (stat),
    .res_o  (res)
  );

  assign eng_done  = run_q && stat.done;
  assign slot_free = !ov_q || result_o.ready;
  assign accept    = point_i.valid && (st_q == S_IDLE);
  assign push      = slot_free && ((st_q == S_PUSH_K) || (st_q == S_PUSH_E));

  // Sequencer and path history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      run_q    <= 1'b0;
      ps_q     <= '0;
      acc_on_q <= 1'b0;
      ox_q     <= '0;
      oy_q     <= '0;
      nx_q     <= '0;
      ny_q     <= '0;
      pk_q     <= '0;
      pr_q     <= '0;
      ov_q     <= 1'b0;
    end else begin
      if (result_o.ready && !push) ov_q <= 1'b0;
      if (cmd.go) run_q <= 1'b1;
      if (eng_done) run_q <= 1'b0;
      case (st_q)
        S_IDLE: begin
          if (accept) begin
            if (ps_q == 2'd0) begin
              if (point_i.end_of_path) begin
                st_q <= S_PUSH_E;
              end else begin
                ox_q <= nx_q;
                oy_q <= ny_q;
                nx_q <= point_i.pos_x;
                ny_q <= point_i.pos_y;
                ps_q <= 2'd1;
              end
            end else if (ps_q == 2'd1) begin
              st_q <= S_PUSH_K;
            end else begin
              st_q <= S_CH_X;
            end
          end
        end
        S_CH_X:  if (eng_done) st_q <= S_CH_Y;
        S_CH_Y:  if (eng_done) st_q <= S_CH_R;
        S_CH_R:  if (eng_done) st_q <= (chord_d == 34'd0) ? after_k : S_LA_X;
        S_LA_X:  if (eng_done) st_q <= S_LA_Y;
        S_LA_Y:  if (eng_done) st_q <= S_LA_R;
        S_LA_R:  if (eng_done) st_q <= S_LB_X;
        S_LB_X:  if (eng_done) st_q <= S_LB_Y;
        S_LB_Y:  if (eng_done) st_q <= S_LB_R;
        S_LB_R: begin
          if (eng_done) begin
            st_q <= ((la_q == 31'd0) || (res[30:0] == 31'd0)) ? after_k : S_DOT_A;
          end
        end
        S_DOT_A: if (eng_done) st_q <= S_DOT_B;
        S_DOT_B: if (eng_done) st_q <= S_DEN;
        S_DEN:   if (eng_done) st_q <= S_COS;
        S_COS:   if (eng_done) st_q <= S_CM;
        S_CM:    if (eng_done) st_q <= S_SIN;
        S_SIN:   if (eng_done) st_q <= S_ACOS;
        S_ACOS:  if (eng_done) st_q <= S_KDIV;
        S_KDIV:  if (eng_done) st_q <= after_k;
        S_DS_X:  if (eng_done) st_q <= S_DS_Y;
        S_DS_Y:  if (eng_done) st_q <= S_DS_R;
        S_DS_R:  if (eng_done) st_q <= (ds_d == 34'd0) ? S_PUSH_K : S_RATE;
        S_RATE:  if (eng_done) st_q <= acc_on_q ? S_ACC : S_PUSH_K;
        S_ACC:   if (eng_done) st_q <= S_PUSH_K;
        S_PUSH_K: begin
          if (slot_free) begin
            ov_q <= 1'b1;
            if (ps_q[1]) begin
              pk_q <= k_q;
              pr_q <= rate_q;
            end
            if (ps_q == 2'd3) acc_on_q <= 1'b1;
            if (end_q) begin
              st_q <= S_PUSH_E;
            end else begin
              ox_q <= nx_q;
              oy_q <= ny_q;
              nx_q <= px_q;
              ny_q <= py_q;
              if (ps_q != 2'd3) ps_q <= ps_q + 2'd1;
              st_q <= S_IDLE;
            end
          end
        end
        S_PUSH_E: begin
          if (slot_free) begin
            ov_q     <= 1'b1;
            ps_q     <= '0;
            acc_on_q <= 1'b0;
            ox_q     <= '0;
            oy_q     <= '0;
            nx_q     <= '0;
            ny_q     <= '0;
            pk_q     <= '0;
            pr_q     <= '0;
            st_q     <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // Working values and the output word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q   <= point_i.pos_x;
      py_q   <= point_i.pos_y;
      end_q  <= point_i.end_of_path;
      cdx_q  <= {point_i.pos_x[31], point_i.pos_x} - {ox_q[31], ox_q};
      cdy_q  <= {point_i.pos_y[31], point_i.pos_y} - {oy_q[31], oy_q};
      ux_q   <= {nx_q[31], nx_q} - {ox_q[31], ox_q};
      uy_q   <= {ny_q[31], ny_q} - {oy_q[31], oy_q};
      vx_q   <= {point_i.pos_x[31], point_i.pos_x} - {nx_q[31], nx_q};
      vy_q   <= {point_i.pos_y[31], point_i.pos_y} - {ny_q[31], ny_q};
      k_q    <= '0;
      rate_q <= '0;
      accl_q <= '0;
    end
    if (eng_done) begin
      case (st_q)
        S_CH_X, S_LA_X, S_LB_X, S_DS_X, S_DEN, S_CM: sum_q <= res;
        S_CH_Y, S_LA_Y, S_LB_Y, S_DS_Y:              sum_q <= sum_q + res;
        S_CH_R:  chord_q <= chord_d;
        S_LA_R:  la_q    <= res[30:0];
        S_LB_R:  lb_q    <= res[30:0];
        S_DOT_A: dot_q   <= p_sgn_a;
        S_DOT_B: dot_q   <= dot_q + p_sgn_b;
        S_COS:   cq_q    <= dot_q[63] ? (~res[31:0] + 32'd1) : res[31:0];
        S_SIN:   sn_q    <= res[31:0];
        S_ACOS:  acos_q  <= res[31:0];
        S_KDIV:  k_q     <= res[31:0];
        S_DS_R:  ds_q    <= ds_d;
        S_RATE:  rate_q  <= dk[32] ? (~res[31:0] + 32'd1) : res[31:0];
        S_ACC:   accl_q  <= dr[32] ? (~res[31:0] + 32'd1) : res[31:0];
        default: ;
      endcase
    end
    if ((st_q == S_PUSH_K) && slot_free) begin
      ok_q <= k_q;
      or_q <= rate_q;
      oa_q <= accl_q;
      ol_q <= 1'b0;
    end
    if ((st_q == S_PUSH_E) && slot_free) begin
      ok_q <= '0;
      or_q <= '0;
      oa_q <= '0;
      ol_q <= 1'b1;
    end
  end

  assign point_i.ready            = (st_q == S_IDLE);
  assign result_o.valid           = ov_q;
  assign result_o.curvature       = ok_q;
  assign result_o.curvature_rate  = or_q;
  assign result_o.curvature_accel = oa_q;
  assign result_o.last_of_path    = ol_q;

  // The engine takes a new command only when it is free
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.go |-> !stat.busy)
    else $error("engine command issued while busy");

  // A held output word stays put until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !result_o.ready) |=> (ov_q && $stable(ok_q) && $stable(or_q) &&
                                   $stable(oa_q) && $stable(ol_q)))
    else $error("output word changed while stalled");

  // The path's last word carries zeros
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ol_q) |-> ((ok_q == 32'd0) && (or_q == 32'd0) && (oa_q == 32'd0)))
    else $error("last word of path is not zero");

  // Curvature is never negative
  assert property (@(posedge clk_i) disable iff (!rst_ni) ov_q |-> !ok_q[31])
    else $error("negative curvature");

endmodule

// ===== design/pc3_engine.sv =====
// ----------------------------------------------------------------------------
// pc3_engine
// Bit-serial arithmetic engine: shift-add multiply (one bit a cycle),
// square root (one root bit a cycle), restoring divide with saturation
// (one quotient bit a cycle) and CORDIC arc cosine (one step a cycle).
// ----------------------------------------------------------------------------
module pc3_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pc3_pkg::eng_cmd_t cmd_i,
  input  logic [63:0]       opa_i,
  input  logic [63:0]       opb_i,
  input  logic [32:0]       cap_i,
  output pc3_pkg::eng_stat_t stat_o,
  output logic [63:0]       res_o
);
  import pc3_pkg::*;

  localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [35:0] PiQ30     = 36'sd3373259426;
  localparam logic [6:0]         CordicLast = 7'd29;
  localparam logic [6:0]         WordLast   = 7'd31;
  localparam logic [6:0]         DivBase    = 7'd63;

  function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
    logic signed [35:0] a;
    case (i)
      5'd0:  a = 36'sd843314857;
      5'd1:  a = 36'sd497837829;
      5'd2:  a = 36'sd263043837;
      5'd3:  a = 36'sd133525159;
      5'd4:  a = 36'sd67021687;
      5'd5:  a = 36'sd33543516;
      5'd6:  a = 36'sd16775851;
      5'd7:  a = 36'sd8388437;
      5'd8:  a = 36'sd4194283;
      5'd9:  a = 36'sd2097149;
      5'd10: a = 36'sd1048576;
      5'd11: a = 36'sd524288;
      5'd12: a = 36'sd262144;
      5'd13: a = 36'sd131072;
      5'd14: a = 36'sd65536;
      5'd15: a = 36'sd32768;
      5'd16: a = 36'sd16384;
      5'd17: a = 36'sd8192;
      5'd18: a = 36'sd4096;
      5'd19: a = 36'sd2048;
      5'd20: a = 36'sd1024;
      5'd21: a = 36'sd512;
      5'd22: a = 36'sd256;
      5'd23: a = 36'sd128;
      5'd24: a = 36'sd64;
      5'd25: a = 36'sd32;
      5'd26: a = 36'sd16;
      5'd27: a = 36'sd8;
      5'd28: a = 36'sd4;
      5'd29: a = 36'sd2;
      default: a = 36'sd0;
    endcase
    return a;
  endfunction

  eng_op_e    op_q;
  logic       busy_q, done_q;
  logic [6:0] cnt_q, lim_q;

  // multiply
  logic [63:0] mp_q, mc_q;
  logic [31:0] mr_q;
  // square root
  logic [63:0] sn_q;
  logic [35:0] sr_q;
  logic [31:0] sq_q;
  // divide
  logic [63:0] dn_q, dd_q, dr_q;
  logic [32:0] dq_q, cap_q;
  logic        dov_q;
  // cordic
  logic signed [35:0] x_q, y_q, z_q;
  logic               zfix_q, zneg_q;

  logic [35:0]        s_rn, s_trial;
  logic               s_ge;
  logic [63:0]        d_r2;
  logic               d_ge;
  logic signed [35:0] c_sx, c_sy, c_at, c36, s36, z_cl;
  logic [4:0]         c_i;

  // One step of each unit
  always_comb begin
    s_rn    = {sr_q[33:0], sn_q[63:62]};
    s_trial = {2'b00, sq_q, 2'b01};
    s_ge    = (s_rn >= s_trial);
    d_r2    = {dr_q[62:0], dn_q[63]};
    d_ge    = (d_r2 >= dd_q);
    c_i     = cnt_q[4:0];
    c_sx    = y_q >>> c_i;
    c_sy    = x_q >>> c_i;
    c_at    = atan_q30(c_i);
    c36     = {{4{opa_i[31]}}, opa_i[31:0]};
    s36     = {4'b0000, opb_i[31:0]};
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= OP_MUL;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      lim_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.go) begin
        op_q   <= cmd_i.op;
        busy_q <= 1'b1;
        cnt_q  <= '0;
        case (cmd_i.op)
          OP_DIV:  lim_q <= DivBase + {2'b00, cmd_i.fbits};
          OP_ACOS: lim_q <= CordicLast;
          default: lim_q <= WordLast;
        endcase
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == lim_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Load operands, then advance one digit a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.go) begin
      case (cmd_i.op)
        OP_MUL: begin
          mp_q <= '0;
          mc_q <= {32'd0, opa_i[31:0]};
          mr_q <= opb_i[31:0];
        end
        OP_SQRT: begin
          sn_q <= opa_i;
          sr_q <= '0;
          sq_q <= '0;
        end
        OP_DIV: begin
          dn_q  <= opa_i;
          dd_q  <= opb_i;
          dr_q  <= '0;
          dq_q  <= '0;
          dov_q <= 1'b0;
          cap_q <= cap_i;
        end
        default: begin
          zfix_q <= (opb_i[31:0] == 32'd0);
          zneg_q <= opa_i[31];
          if (!opa_i[31]) begin
            x_q <= c36;
            y_q <= s36;
            z_q <= '0;
          end else begin
            x_q <= s36;
            y_q <= -c36;
            z_q <= HalfPiQ30;
          end
        end
      endcase
    end else if (busy_q) begin
      case (op_q)
        OP_MUL: begin
          if (mr_q[0]) mp_q <= mp_q + mc_q;
          mc_q <= {mc_q[62:0], 1'b0};
          mr_q <= {1'b0, mr_q[31:1]};
        end
        OP_SQRT: begin
          sn_q <= {sn_q[61:0], 2'b00};
          sr_q <= s_ge ? (s_rn - s_trial) : s_rn;
          sq_q <= {sq_q[30:0], s_ge};
        end
        OP_DIV: begin
          dn_q  <= {dn_q[62:0], 1'b0};
          dr_q  <= d_ge ? (d_r2 - dd_q) : d_r2;
          dq_q  <= {dq_q[31:0], d_ge};
          dov_q <= dov_q | dq_q[32];
        end
        default: begin
          if (y_q > 36'sd0) begin
            x_q <= x_q + c_sx;
            y_q <= y_q - c_sy;
            z_q <= z_q + c_at;
          end else begin
            x_q <= x_q - c_sx;
            y_q <= y_q + c_sy;
            z_q <= z_q - c_at;
          end
        end
      endcase
    end
  end

  // Final result: pass the product or root, saturate the quotient, clamp the angle
  always_comb begin
    z_cl = z_q;
    if (z_q < 36'sd0) z_cl = '0;
    if (z_q > PiQ30)  z_cl = PiQ30;
    if (zfix_q)       z_cl = zneg_q ? PiQ30 : 36'sd0;
    case (op_q)
      OP_MUL:  res_o = mp_q;
      OP_SQRT: res_o = {32'd0, sq_q};
      OP_DIV:  res_o = {31'd0, ((dov_q || (dq_q > cap_q)) ? cap_q : dq_q)};
      default: res_o = {28'd0, z_cl};
    endcase
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
